// ===== hw/rtl/frq_pkg.sv =====
// Shared types and constants for the receive frame queue.
package frq_pkg;

	localparam int SLOTS       = 8;
	localparam int SLOT_BYTES  = 2048;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int OFF_W       = $clog2(SLOT_BYTES);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int SUM_W       = SLOT_W + 1;
	localparam int STORE_DEPTH = SLOTS << OFF_W;
	localparam int STORE_AW    = SLOT_W + OFF_W;

	localparam int LEN_W       = 12;
	localparam int HELD_W      = 4;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int BYTE_W      = 8;
	localparam int CFG_AW      = 2;
	localparam int CFG_DW      = 12;

	localparam logic [LEN_W-1:0]  LEN_SAT      = '1;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 12'd1536;
	localparam logic [BYTE_W-1:0] BYTE_ONES    = 8'hFF;
	localparam int                DEST_BYTES   = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_COMMITTED  = 3'd1,
		ST_FILTERED   = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_QUEUE_FULL = 3'd4,
		ST_READ_BYTE  = 3'd5,
		ST_READ_EMPTY = 3'd6
	} frq_status_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_PASS_UC  = 2'd0,
		CFG_PASS_MC  = 2'd1,
		CFG_PASS_BC  = 2'd2,
		CFG_MAX_LEN  = 2'd3
	} cfg_idx_t;

endpackage

// ===== hw/rtl/frq_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module frq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/rx_frame_queue_with_dest_filter_core.sv =====
// Receive frame queue with destination-type filter: control, slot table and output stage.
//
//  channel | dir | handshake             | payload
//  s_*     | in  | s_tvalid / s_tready   | tuser cmd, tdata rx_byte, tlast rx_last
//  m_*     | out | m_tvalid / m_tready   | tdata byte/valid/held, tuser status, tlast pop
//  cfg_*   | in  | cfg_we                | cfg_addr register index, cfg_wdata value
//
// One word accepted per cycle while s_tready is high; the read stage and the frame
// store read load at the accepting edge, the output register when the read stage
// advances, so the result reaches m_* from the output register.
// State updates at the edge a word is accepted; no clearing pass after reset.
// A stalled output holds the read stage; while the output word waits, a new word
// is taken only if the read stage is empty.
module rx_frame_queue_with_dest_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [frq_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
	input  logic [frq_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
	input  logic                          s_tlast,   // rx_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [7:0] out_byte, [8] out_valid,
	                                                 // [12:9] frames_held, [15:13] zero
	output logic [frq_pkg::STATUS_W-1:0]  m_tuser,   // [2:0] status
	output logic                          m_tlast,   // out_last
	input  logic                          cfg_we,
	input  logic [frq_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [frq_pkg::CFG_DW-1:0]    cfg_wdata
);
	import frq_pkg::*;

	logic              pass_uc_q, pass_mc_q, pass_bc_q;
	logic [LEN_W-1:0]  max_len_q;

	logic [SLOT_W-1:0] head_q, head_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [LEN_W-1:0]  woff_q, woff_n;
	logic [LEN_W-1:0]  roff_q, roff_n;
	logic              open_q, open_n;
	logic              disc_q, disc_n;
	logic              ones_q, ones_n;
	logic              grp_q, grp_n;
	logic [LEN_W-1:0]  slot_len_q [SLOTS];
	logic              slen_we;

	logic              s1_vld;
	logic              rd_s1, last_s1;
	frq_status_t       status_s1;
	logic [CNT_W-1:0]  held_s1;

	logic              out_vld_q, ovalid_q, olast_q;
	logic [BYTE_W-1:0] obyte_q;
	frq_status_t       status_q;
	logic [CNT_W-1:0]  held_q;

	logic              acc, out_free, adv;
	cmd_t              cmd;
	frq_status_t       st;
	logic              o_rd, o_last;

	logic [SUM_W-1:0]  tail_sum;
	logic [SLOT_W-1:0] tail, head_inc;
	logic [LEN_W-1:0]  cur_off, len, ro;
	logic              cur_disc, cur_ones, cur_grp, bcast, pass;
	logic [LEN_W-1:0]  head_len;

	logic                mem_we, mem_re;
	logic [STORE_AW-1:0] waddr, raddr;
	logic [BYTE_W-1:0]   rdata;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = !s1_vld || out_free;
	assign acc      = s_tvalid && s_tready;
	assign adv      = s1_vld && out_free;
	assign cmd      = cmd_t'(s_tuser);

	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(SLOTS))
	                                               : SLOT_W'(tail_sum);
	assign head_inc = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign head_len = slot_len_q[head_q];

	assign cur_off  = open_q ? woff_q : '0;
	assign cur_disc = open_q ? disc_q : (count_q >= CNT_W'(SLOTS));
	assign cur_ones = open_q ? ones_q : 1'b1;
	assign cur_grp  = open_q ? grp_q  : 1'b0;
	assign ro       = (32'(roff_q) >= SLOT_BYTES) ? LEN_W'(SLOT_BYTES - 1) : roff_q;
	assign waddr    = {tail, cur_off[OFF_W-1:0]};
	assign raddr    = {head_q, ro[OFF_W-1:0]};

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		woff_n  = woff_q;
		roff_n  = roff_q;
		open_n  = open_q;
		disc_n  = disc_q;
		ones_n  = ones_q;
		grp_n   = grp_q;
		slen_we = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		st      = ST_OK;
		o_rd    = 1'b0;
		o_last  = 1'b0;
		len     = (cur_off < LEN_SAT) ? cur_off + 1'b1 : cur_off;
		bcast   = 1'b0;
		pass    = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_WRITE: begin
					grp_n  = (cur_off == '0) ? s_tdata[0] : cur_grp;
					ones_n = cur_ones && !(32'(cur_off) < DEST_BYTES && s_tdata != BYTE_ONES);
					mem_we = !cur_disc && (32'(cur_off) < SLOT_BYTES);
					if (s_tlast) begin
						if (cur_disc) begin
							st = ST_QUEUE_FULL;
						end else if (len > max_len_q || 32'(len) > SLOT_BYTES ||
						             len == LEN_SAT) begin
							st = ST_TOO_LONG;
						end else begin
							bcast = ones_n && (32'(len) >= DEST_BYTES);
							pass  = bcast ? pass_bc_q : (grp_n ? pass_mc_q : pass_uc_q);
							if (pass) begin
								slen_we = 1'b1;
								count_n = count_q + 1'b1;
								st      = ST_COMMITTED;
							end else begin
								st = ST_FILTERED;
							end
						end
						open_n = 1'b0;
						disc_n = 1'b0;
						woff_n = '0;
						ones_n = 1'b1;
						grp_n  = 1'b0;
					end else begin
						open_n = 1'b1;
						disc_n = cur_disc;
						woff_n = len;
					end
				end
				CMD_READ: begin
					if (count_q == '0) begin
						st = ST_READ_EMPTY;
					end else begin
						mem_re = 1'b1;
						o_rd   = 1'b1;
						st     = ST_READ_BYTE;
						if ((LEN_W+1)'(roff_q) + 1'b1 >= (LEN_W+1)'(head_len)) begin
							o_last  = 1'b1;
							roff_n  = '0;
							head_n  = head_inc;
							count_n = count_q - 1'b1;
						end else begin
							roff_n = roff_q + 1'b1;
						end
					end
				end
				CMD_CLEAR: begin
					count_n = '0;
					roff_n  = '0;
					open_n  = 1'b0;
					disc_n  = 1'b0;
					woff_n  = '0;
					ones_n  = 1'b1;
					grp_n   = 1'b0;
				end
				default: begin
					st = ST_OK;
				end
			endcase
		end
	end

	frq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (s_tdata),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_uc_q <= 1'b1;
			pass_mc_q <= 1'b1;
			pass_bc_q <= 1'b1;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_PASS_UC: pass_uc_q <= cfg_wdata[0];
				CFG_PASS_MC: pass_mc_q <= cfg_wdata[0];
				CFG_PASS_BC: pass_bc_q <= cfg_wdata[0];
				CFG_MAX_LEN: max_len_q <= cfg_wdata[LEN_W-1:0];
				default:     max_len_q <= max_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			woff_q  <= '0;
			roff_q  <= '0;
			open_q  <= 1'b0;
			disc_q  <= 1'b0;
			ones_q  <= 1'b1;
			grp_q   <= 1'b0;
		end else begin
			head_q  <= head_n;
			count_q <= count_n;
			woff_q  <= woff_n;
			roff_q  <= roff_n;
			open_q  <= open_n;
			disc_q  <= disc_n;
			ones_q  <= ones_n;
			grp_q   <= grp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (slen_we) begin
			slot_len_q[tail] <= len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_vld <= 1'b1;
			end else if (adv) begin
				s1_vld <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= o_rd;
			last_s1   <= o_last;
			status_s1 <= st;
			held_s1   <= count_n;
		end
		if (adv) begin
			obyte_q  <= rd_s1 ? rdata : '0;
			ovalid_q <= rd_s1;
			olast_q  <= last_s1;
			status_q <= status_s1;
			held_q   <= held_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, HELD_W'(held_q), ovalid_q, obyte_q};
	assign m_tuser  = status_q;
	assign m_tlast  = olast_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("committed frame count above slot count");

	a_disc_open: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> open_q)
		else $error("discard flag set outside an open frame");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && ovalid_q |-> status_q == ST_READ_BYTE)
		else $error("byte marked valid without read status");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld && !out_free |=> s1_vld && $stable(status_s1))
		else $error("read stage lost a word while output stalled");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == CMD_READ && count_q == '0 |=> count_q == '0)
		else $error("read of empty queue changed frame count");

endmodule
